/* hdl/owss_pkg.sv */
package owss_pkg;

    // quarter-wave sine table resolution, valid range 6..14
    localparam int unsigned SINE_TABLE_BITS = 10;
    localparam int unsigned TAB_N = 1 << SINE_TABLE_BITS;

    // register stages from command transaction to result register
    localparam int unsigned PIPE_DEPTH = 7;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [14:0] sine_rom_t [0:TAB_N];
    typedef logic [SINE_TABLE_BITS:0] sine_idx_t;

    typedef logic [2:0] cfg_addr_t;
    localparam cfg_addr_t CFG_SCALE_GAIN = 3'd0;
    localparam cfg_addr_t CFG_FRONT_X    = 3'd1;
    localparam cfg_addr_t CFG_SIDE_Y     = 3'd2;
    localparam cfg_addr_t CFG_REAR_X     = 3'd3;
    localparam cfg_addr_t CFG_MOUNT_COS  = 3'd4;
    localparam cfg_addr_t CFG_MOUNT_SIN  = 3'd5;

    typedef struct packed {
        logic signed [15:0] x_vel;
        logic signed [15:0] y_vel;
        logic signed [15:0] spin_rate;
        logic        [15:0] heading;
    } owss_cmd_t;

    typedef struct packed {
        logic signed [15:0] wheel_one_speed;
        logic signed [15:0] wheel_two_speed;
        logic signed [15:0] wheel_three_speed;
    } owss_wheel_t;

    // sin(pi/2 * i / TAB_N) in Q15, Horner Taylor series in Q30
    function automatic logic [14:0] sine_q15(int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return 15'(s);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int unsigned i = 0; i <= TAB_N; i++)
        begin
            rom[i] = sine_q15(i);
        end
        return rom;
    endfunction

endpackage

/* hdl/omni_wheel_speed_solver_unit.sv */
// Inverse kinematics for a three-wheel omni base. Each command transaction
// (x/y velocity, spin rate, heading) yields one transaction of three wheel
// speeds in Q4.12, saturated. The block is a 7-stage pipeline: a sine/cosine
// ROM read, the rotation products, the rotation sums, the gain multiply,
// rounding plus spin terms, the wheel projections, and the final rounding
// and saturation into the result register. It takes one command per cycle
// while not stalled; the whole pipeline holds only while a result waits on
// wheel_ready. Configuration writes are taken every cycle and should only be
// issued while no command is in flight.
module omni_wheel_speed_solver_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  owss_pkg::owss_cmd_t   cmd,
    output logic                  wheel_valid,
    input  logic                  wheel_ready,
    output owss_pkg::owss_wheel_t wheel,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  owss_pkg::cfg_addr_t   cfg_index,
    input  logic [15:0]           cfg_data
);
    import owss_pkg::*;

    localparam sine_rom_t SINE_ROM = build_sine_rom();
    localparam sine_idx_t TAB_N_IDX = {1'b1, {SINE_TABLE_BITS{1'b0}}};

    localparam logic signed [49:0] ROUND14 = 50'sd8192;
    localparam logic signed [53:0] ROUND30 = 54'sd536870912;

    // configuration registers
    logic        [15:0] scale_gain_reg;
    logic signed [15:0] front_x_reg;
    logic signed [15:0] side_y_reg;
    logic signed [15:0] rear_x_reg;
    logic signed [15:0] mount_cos_reg;
    logic signed [15:0] mount_sin_reg;

    logic en;

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, wheel_valid_reg;

    // stage 1
    logic signed [15:0] vx1_reg, vy1_reg, w1_reg;
    logic               sq1_reg, cq1_reg;
    logic        [14:0] sin_mag_reg, cos_mag_reg;
    logic        [1:0]  sq_next, cq_next;
    sine_idx_t          sin_idx_next, cos_idx_next;
    sine_idx_t          raw_idx;

    // stage 2
    logic signed [15:0] sin_val, cos_val;
    logic signed [31:0] cvx_reg, svy_reg, cvy_reg, svx_reg;
    logic signed [31:0] wsy2_reg, wfx2_reg, wrx2_reg;
    logic signed [31:0] cvx_next, svy_next, cvy_next, svx_next;
    logic signed [31:0] wsy_next, wfx_next, wrx_next;

    // stage 3
    logic signed [32:0] rx_reg, ry_reg;
    logic signed [32:0] rx_next, ry_next;
    logic signed [31:0] wsy3_reg, wfx3_reg, wrx3_reg;

    // stage 4
    logic signed [16:0] gain_s;
    logic signed [49:0] px_reg, py_reg;
    logic signed [49:0] px_next, py_next;
    logic signed [31:0] wsy4_reg, wfx4_reg, wrx4_reg;

    // stage 5
    logic signed [35:0] tx, ty;
    logic signed [36:0] wx1_reg, wx2_reg, wy12_reg, wy3_reg;
    logic signed [36:0] wx1_next, wx2_next, wy12_next, wy3_next;

    // stage 6
    logic signed [52:0] a1_reg, b1_reg, a2_reg, l3_reg;
    logic signed [52:0] a1_next, b1_next, a2_next, l3_next;

    // stage 7
    logic signed [53:0] l1, l2, l3;
    logic signed [23:0] r1, r2, r3;
    owss_wheel_t        wheel_reg;
    owss_wheel_t        wheel_next;

    function automatic logic signed [15:0] sat16(logic signed [23:0] v);
        priority if (v > 24'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -24'sd32768)
        begin
            return 16'sh8000;
        end
        else
        begin
            return 16'(v);
        end
    endfunction

    assign en          = !wheel_valid_reg || wheel_ready;
    assign cmd_ready   = en;
    assign cfg_ready   = 1'b1;
    assign wheel_valid = wheel_valid_reg;
    assign wheel       = wheel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_gain_reg <= 16'd18842;
            front_x_reg    <= 16'sd819;
            side_y_reg     <= 16'sd2248;
            rear_x_reg     <= -16'sd2392;
            mount_cos_reg  <= 16'sd30792;
            mount_sin_reg  <= 16'sd11207;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SCALE_GAIN: scale_gain_reg <= cfg_data;
                CFG_FRONT_X:    front_x_reg    <= $signed(cfg_data);
                CFG_SIDE_Y:     side_y_reg     <= $signed(cfg_data);
                CFG_REAR_X:     rear_x_reg     <= $signed(cfg_data);
                CFG_MOUNT_COS:  mount_cos_reg  <= $signed(cfg_data);
                CFG_MOUNT_SIN:  mount_sin_reg  <= $signed(cfg_data);
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            v5_reg          <= 1'b0;
            v6_reg          <= 1'b0;
            wheel_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg          <= cmd_valid;
            v2_reg          <= v1_reg;
            v3_reg          <= v2_reg;
            v4_reg          <= v3_reg;
            v5_reg          <= v4_reg;
            v6_reg          <= v5_reg;
            wheel_valid_reg <= v6_reg;
        end
    end

    // stage 1: table addresses; cos uses the next quadrant
    always_comb
    begin
        raw_idx = {1'b0, cmd.heading[13 -: SINE_TABLE_BITS]};
        sq_next = cmd.heading[15:14];
        cq_next = cmd.heading[15:14] + 2'd1;
        sin_idx_next = sq_next[0] ? TAB_N_IDX - raw_idx : raw_idx;
        cos_idx_next = cq_next[0] ? TAB_N_IDX - raw_idx : raw_idx;
    end

    // stage 2: signed sin/cos and first products
    always_comb
    begin
        sin_val  = sq1_reg ? -$signed({1'b0, sin_mag_reg}) : $signed({1'b0, sin_mag_reg});
        cos_val  = cq1_reg ? -$signed({1'b0, cos_mag_reg}) : $signed({1'b0, cos_mag_reg});
        cvx_next = 32'(cos_val) * 32'(vx1_reg);
        svy_next = 32'(sin_val) * 32'(vy1_reg);
        cvy_next = 32'(cos_val) * 32'(vy1_reg);
        svx_next = 32'(sin_val) * 32'(vx1_reg);
        wsy_next = 32'(w1_reg) * 32'(side_y_reg);
        wfx_next = 32'(w1_reg) * 32'(front_x_reg);
        wrx_next = 32'(w1_reg) * 32'(rear_x_reg);
    end

    // stage 3: rotation sums
    always_comb
    begin
        rx_next = 33'(cvx_reg) + 33'(svy_reg);
        ry_next = 33'(cvy_reg) - 33'(svx_reg);
    end

    // stage 4: translation gain
    always_comb
    begin
        gain_s  = $signed({1'b0, scale_gain_reg});
        px_next = 50'(rx_reg) * 50'(gain_s);
        py_next = 50'(ry_reg) * 50'(gain_s);
    end

    // stage 5: back to Q.27, add unscaled spin terms
    always_comb
    begin
        tx        = 36'((px_reg + ROUND14) >>> 14);
        ty        = 36'((py_reg + ROUND14) >>> 14);
        wx1_next  = 37'(tx) + 37'(wsy4_reg);
        wx2_next  = 37'(tx) - 37'(wsy4_reg);
        wy12_next = 37'(ty) + 37'(wfx4_reg);
        wy3_next  = 37'(ty) + 37'(wrx4_reg);
    end

    // stage 6: projections; wheel three is a scale by -1.0 in Q1.15
    always_comb
    begin
        a1_next = 53'(wx1_reg) * 53'(mount_cos_reg);
        a2_next = 53'(wx2_reg) * 53'(mount_cos_reg);
        b1_next = 53'(wy12_reg) * 53'(mount_sin_reg);
        l3_next = -(53'(wy3_reg) <<< 15);
    end

    // stage 7: sum, round by 30 bits, saturate
    always_comb
    begin
        l1 = 54'(a1_reg) + 54'(b1_reg);
        l2 = 54'(a2_reg) - 54'(b1_reg);
        l3 = 54'(l3_reg);
        r1 = 24'((l1 + ROUND30) >>> 30);
        r2 = 24'((l2 + ROUND30) >>> 30);
        r3 = 24'((l3 + ROUND30) >>> 30);
        wheel_next.wheel_one_speed   = sat16(r1);
        wheel_next.wheel_two_speed   = sat16(r2);
        wheel_next.wheel_three_speed = sat16(r3);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx1_reg     <= cmd.x_vel;
            vy1_reg     <= cmd.y_vel;
            w1_reg      <= cmd.spin_rate;
            // only the sign half of each quadrant is needed downstream
            sq1_reg     <= sq_next[1];
            cq1_reg     <= cq_next[1];
            sin_mag_reg <= SINE_ROM[sin_idx_next];
            cos_mag_reg <= SINE_ROM[cos_idx_next];

            cvx_reg  <= cvx_next;
            svy_reg  <= svy_next;
            cvy_reg  <= cvy_next;
            svx_reg  <= svx_next;
            wsy2_reg <= wsy_next;
            wfx2_reg <= wfx_next;
            wrx2_reg <= wrx_next;

            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            wsy3_reg <= wsy2_reg;
            wfx3_reg <= wfx2_reg;
            wrx3_reg <= wrx2_reg;

            px_reg   <= px_next;
            py_reg   <= py_next;
            wsy4_reg <= wsy3_reg;
            wfx4_reg <= wfx3_reg;
            wrx4_reg <= wrx3_reg;

            wx1_reg  <= wx1_next;
            wx2_reg  <= wx2_next;
            wy12_reg <= wy12_next;
            wy3_reg  <= wy3_next;

            a1_reg <= a1_next;
            a2_reg <= a2_next;
            b1_reg <= b1_next;
            l3_reg <= l3_next;

            wheel_reg <= wheel_next;
        end
    end

endmodule

/* hdl/owss_checker.sv */
module owss_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_ready,
    input logic                  wheel_valid,
    input logic                  wheel_ready,
    input owss_pkg::owss_wheel_t wheel,
    input logic                  cfg_valid,
    input logic                  cfg_ready
);
    import owss_pkg::*;

    localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             cmd_fire;
    logic             wheel_fire;

    assign cmd_fire   = cmd_valid && cmd_ready;
    assign wheel_fire = wheel_valid && wheel_ready;

    // transactions accepted but not yet delivered
    always_comb
    begin
        count_next = count_reg;
        if (cmd_fire && !wheel_fire)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (wheel_fire && !cmd_fire)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_wheel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wheel_valid && !wheel_ready |=> wheel_valid && $stable(wheel))
        else $error("result changed or dropped while stalled");

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready == (!wheel_valid || wheel_ready))
        else $error("cmd_ready does not track output stall");

    a_in_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more transactions in flight than pipeline stages");

    a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
        wheel_valid |-> count_reg != '0)
        else $error("result offered with no command in flight");

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind omni_wheel_speed_solver_unit owss_checker u_owss_checker (.*);
